@@ rtl/core/ple_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ple_pkg: shared types for the positional list engine
// Request codes, result status codes and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ple_pkg;

	// Request codes as they arrive on the func field.
	typedef enum logic [2:0] {
		FUNC_GET      = 3'd0,
		FUNC_INS_HEAD = 3'd1,
		FUNC_APPEND   = 3'd2,
		FUNC_INS_POS  = 3'd3,
		FUNC_DELETE   = 3'd4
	} ple_func_e_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_ABSENT = 2'd1,
		ST_FULL   = 2'd2
	} ple_status_e_t;

	// Read address source for the entry store.
	typedef enum logic [1:0] {
		RD_POS,
		RD_BELOW,
		RD_ABOVE
	} ple_rd_sel_t;

	// Update of the walking index.
	typedef enum logic [2:0] {
		IDX_HOLD,
		IDX_DEC,
		IDX_INC,
		IDX_COUNT,
		IDX_POS
	} ple_idx_op_t;

	// Write requested by the controller (shift write-backs are implicit).
	typedef enum logic [1:0] {
		WR_NONE,
		WR_VAL_POS,
		WR_VAL_COUNT,
		WR_PAD_COUNT
	} ple_wr_sel_t;

	// Source of the read_value field of a result.
	typedef enum logic [1:0] {
		RES_ZERO,
		RES_ONES,
		RES_MEM
	} ple_res_sel_t;

	typedef struct packed {
		logic          load;
		logic          rd_en;
		ple_rd_sel_t   rd_sel;
		ple_idx_op_t   idx_op;
		ple_wr_sel_t   wr_sel;
		logic          cnt_inc;
		logic          cnt_dec;
		logic          res_load;
		ple_status_e_t res_status;
		ple_res_sel_t  res_sel;
	} ple_cmd_t;

	typedef struct packed {
		ple_func_e_t func;
		logic        in_range;
		logic        full;
		logic        pad_ok;
		logic        up_more;
		logic        dn_more;
		logic        pad_more;
		logic        pend;
	} ple_sts_t;

endpackage : ple_pkg
`default_nettype wire

@@ rtl/core/ple_dpath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ple_dpath: datapath of the positional list engine
// Holds the entry store, the entry count, the request registers, the walking
// index and the result registers, and reports compare flags to the controller.
// ----------------------------------------------------------------------------
module ple_dpath #(
	parameter int CAPACITY = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ple_pkg::ple_cmd_t  cmd,
	output ple_pkg::ple_sts_t       sts,
	input  wire logic [2:0]         func,
	input  wire logic [7:0]         position,
	input  wire logic signed [31:0] item_value,
	output logic signed [31:0]      read_value,
	output logic [1:0]              status,
	output logic [6:0]              count_after
);
	import ple_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam int XW = ((CW > 8) ? CW : 8) + 1;

	logic [31:0]   mem [CAPACITY];
	ple_func_e_t   func_q;
	logic [7:0]    pos_q;
	logic [31:0]   val_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [31:0]   rdata_q;
	logic          pend_s1;
	logic [CW-1:0] pend_addr_s1;

	logic [XW-1:0] pos_x, count_x, idx_x;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [31:0]   wr_data;
	logic          wr_en;

	assign pos_x   = XW'(pos_q);
	assign count_x = XW'(count_q);
	assign idx_x   = XW'(idx_q);

	always_comb begin
		sts.func     = func_q;
		sts.in_range = pos_x < count_x;
		sts.full     = count_x == XW'(CAPACITY);
		sts.pad_ok   = pos_x < XW'(CAPACITY);
		sts.up_more  = idx_x > pos_x;
		sts.dn_more  = (idx_x + XW'(1)) < count_x;
		sts.pad_more = count_x < pos_x;
		sts.pend     = pend_s1;
	end

	always_comb begin
		case (cmd.rd_sel)
			RD_BELOW: rd_addr = AW'(idx_x - XW'(1));
			RD_ABOVE: rd_addr = AW'(idx_x + XW'(1));
			default:  rd_addr = AW'(pos_x);
		endcase
	end

	// A pending shift write-back takes the port; the controller never asks
	// for a write of its own in that cycle.
	always_comb begin
		wr_en   = 1'b1;
		wr_addr = AW'(count_x);
		wr_data = val_q;
		if (pend_s1) begin
			wr_addr = AW'(pend_addr_s1);
			wr_data = rdata_q;
		end else begin
			case (cmd.wr_sel)
				WR_VAL_POS:   wr_addr = AW'(pos_x);
				WR_VAL_COUNT: wr_addr = AW'(count_x);
				WR_PAD_COUNT: wr_data = '1;
				default:      wr_en = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			pend_s1      <= 1'b0;
			pend_addr_s1 <= '0;
			idx_q        <= '0;
		end else begin
			pend_s1      <= cmd.rd_en && (cmd.rd_sel != RD_POS);
			pend_addr_s1 <= idx_q;
			if (cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
			case (cmd.idx_op)
				IDX_DEC:   idx_q <= idx_q - CW'(1);
				IDX_INC:   idx_q <= idx_q + CW'(1);
				IDX_COUNT: idx_q <= count_q;
				IDX_POS:   idx_q <= CW'(pos_x);
				default:   idx_q <= idx_q;
			endcase
		end
	end

	// Request and result payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= ple_func_e_t'(func);
			pos_q  <= (func == FUNC_INS_HEAD) ? 8'd0 : position;
			val_q  <= item_value;
		end
		if (cmd.res_load) begin
			case (cmd.res_sel)
				RES_ONES: read_value <= '1;
				RES_MEM:  read_value <= rdata_q;
				default:  read_value <= '0;
			endcase
			status      <= cmd.res_status;
			count_after <= 7'(count_q);
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count beyond capacity");

	a_no_wr_clash: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (cmd.wr_sel == WR_NONE))
		else $error("write request while a shift write-back is pending");

	a_res_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> !pend_s1)
		else $error("result loaded before the shift drained");
`endif
endmodule : ple_dpath
`default_nettype wire

@@ rtl/core/ple_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ple_ctrl: controller of the positional list engine
// Sequences each request through the datapath and owns both handshakes.
// ----------------------------------------------------------------------------
module ple_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire ple_pkg::ple_sts_t sts,
	output ple_pkg::ple_cmd_t      cmd
);
	import ple_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SHIFT_UP,
		S_SHIFT_DN,
		S_PAD,
		S_FINISH
	} state_t;

	state_t        state_q, state_d;
	ple_status_e_t st_q, st_d;
	ple_res_sel_t  rs_q, rs_d;
	logic          out_valid_q, ov_d;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		st_d    = st_q;
		rs_d    = rs_q;
		ov_d    = out_valid_q && !out_ready;
		cmd.res_status = st_q;
		cmd.res_sel    = rs_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				st_d    = ST_DONE;
				rs_d    = RES_ZERO;
				state_d = S_FINISH;
				unique case (sts.func) inside
					FUNC_GET: begin
						if (sts.in_range) begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RD_POS;
							rs_d       = RES_MEM;
						end else begin
							rs_d = RES_ONES;
							st_d = ST_ABSENT;
						end
					end
					FUNC_APPEND: begin
						if (sts.full) begin
							st_d = ST_FULL;
						end else begin
							cmd.wr_sel  = WR_VAL_COUNT;
							cmd.cnt_inc = 1'b1;
						end
					end
					FUNC_INS_HEAD, FUNC_INS_POS: begin
						if (sts.in_range) begin
							if (sts.full) begin
								st_d = ST_FULL;
							end else begin
								cmd.idx_op = IDX_COUNT;
								state_d    = S_SHIFT_UP;
							end
						end else if (!sts.pad_ok) begin
							st_d = ST_FULL;
						end else begin
							state_d = S_PAD;
						end
					end
					FUNC_DELETE: begin
						if (sts.in_range) begin
							cmd.idx_op = IDX_POS;
							state_d    = S_SHIFT_DN;
						end else begin
							st_d = ST_ABSENT;
						end
					end
					default: begin
						state_d = S_FINISH;
					end
				endcase
			end
			S_SHIFT_UP: begin
				if (sts.up_more) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_BELOW;
					cmd.idx_op = IDX_DEC;
				end else if (!sts.pend) begin
					cmd.wr_sel  = WR_VAL_POS;
					cmd.cnt_inc = 1'b1;
					state_d     = S_FINISH;
				end
			end
			S_SHIFT_DN: begin
				if (sts.dn_more) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_ABOVE;
					cmd.idx_op = IDX_INC;
				end else if (!sts.pend) begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_FINISH;
				end
			end
			S_PAD: begin
				cmd.cnt_inc = 1'b1;
				if (sts.pad_more) begin
					cmd.wr_sel = WR_PAD_COUNT;
				end else begin
					cmd.wr_sel = WR_VAL_COUNT;
					state_d    = S_FINISH;
				end
			end
			S_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.res_load = 1'b1;
					ov_d         = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			st_q        <= ST_DONE;
			rs_q        <= RES_ZERO;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			st_q        <= st_d;
			rs_q        <= rs_d;
			out_valid_q <= ov_d;
		end
	end

`ifndef SYNTHESIS
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_EXEC))
		else $error("accepted item did not start execution");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten while still held");

	a_one_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.cnt_inc && cmd.cnt_dec))
		else $error("count incremented and decremented together");
`endif
endmodule : ple_ctrl
`default_nettype wire

@@ rtl/core/positional_list_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_engine: ordered list of signed 32-bit values
// Get, insert at head, append, insert at position and delete at position
// on a list of up to CAPACITY entries held in a single-port-write memory.
// ----------------------------------------------------------------------------
// The engine works on one request at a time. A request is taken when in_valid
// and in_ready are both high; in_ready is high only while the engine is idle.
// Each request yields exactly one result item on the out channel, held in an
// output register, so the engine can finish its next request while a result
// waits, but delivers it only once the previous one has been taken. The entry
// store has one write and one registered read port. An insert inside the list
// shifts each entry at or above the position up by one place, a delete shifts
// each entry above the position down by one, and an insert past the end pads
// with -1 values up to the position. Inserts that do not fit are dropped
// whole and report full; gets and deletes of absent positions report not
// present. The store needs no clearing after reset, since only positions
// below the entry count are ever read.
// ----------------------------------------------------------------------------
module positional_list_engine #(
	parameter int CAPACITY = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [2:0]         func,
	input  wire logic [7:0]         position,
	input  wire logic signed [31:0] item_value,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      read_value,
	output logic [1:0]              status,
	output logic [6:0]              count_after
);
	import ple_pkg::*;

	// Commands flow from the controller to the datapath; compare flags
	// and the latched request code flow back.
	ple_cmd_t cmd;
	ple_sts_t sts;

	ple_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ple_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.func        (func),
		.position    (position),
		.item_value  (item_value),
		.read_value  (read_value),
		.status      (status),
		.count_after (count_after)
	);

endmodule : positional_list_engine
`default_nettype wire

@@ test/positional_list_engine_test.sv @@
// ----------------------------------------------------------------------------
// positional_list_engine_test: self-checking bench for the positional list
// Drives get, insert, append, insert-at-position and delete requests, keeps
// its own copy of the list, and compares every result item field by field.
// ----------------------------------------------------------------------------
module positional_list_engine_test;
	timeunit 1ns;
	timeprecision 1ps;

	import ple_pkg::*;

	// Bench constants. The list capacity matches the default of the block.
	localparam int          LIST_CAPACITY = 64;
	localparam int          CLK_PERIOD    = 12;
	localparam int          RESET_CYCLES  = 4;
	localparam int          PHASE_ITEMS   = 360;
	localparam int          HOLD_CYCLES   = 400;
	localparam int          DRAIN_CYCLES  = 80;
	localparam int          LIMIT_CYCLES  = 1000000;
	localparam logic [31:0] VAL_MAX       = 32'h7FFF_FFFF;
	localparam logic [31:0] VAL_MIN       = 32'h8000_0000;
	localparam logic [31:0] PAD_WORD      = 32'hFFFF_FFFF;

	// Request codes that the package leaves unnamed; the block must treat
	// them as no operation.
	localparam logic [2:0] FUNC_SPARE_LO  = 3'd5;
	localparam logic [2:0] FUNC_SPARE_MID = 3'd6;
	localparam logic [2:0] FUNC_SPARE_HI  = 3'd7;

	// One expected result item.
	typedef struct packed {
		logic [31:0]   read_value;
		ple_status_e_t status;
		logic [6:0]    count_after;
	} list_result_t;

	// One row of the directed table. Where typed is set, the expected result
	// is written into the row; otherwise the list model supplies it.
	typedef struct packed {
		logic [2:0]   op;
		logic [7:0]   pos;
		logic [31:0]  val;
		logic         typed;
		list_result_t want;
	} directed_row_t;

	// Clock and reset. Every input of the block is known from time zero.
	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        in_valid   = 1'b0;
	logic [2:0]  func       = '0;
	logic [7:0]  position   = '0;
	logic [31:0] item_value = '0;
	logic        out_ready  = 1'b0;

	logic              in_ready;
	logic              out_valid;
	logic signed [31:0] read_value;
	logic [1:0]        status;
	logic [6:0]        count_after;

	always #(CLK_PERIOD / 2) clk = ~clk;

	positional_list_engine #(
		.CAPACITY(LIST_CAPACITY)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.position   (position),
		.item_value (item_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.read_value (read_value),
		.status     (status),
		.count_after(count_after)
	);

	// Our own copy of the list: the stored words and the number in use.
	logic [31:0] list_store [LIST_CAPACITY];
	int          list_len = 0;

	// Results that the block still owes us, oldest first.
	list_result_t awaited_results [$];
	directed_row_t directed_rows [$];

	// Handshake pacing, set per phase by the main process. A long hold-off of
	// the receiver is requested through hold_req and counted down on its own.
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	bit hold_req       = 1'b0;
	int hold_left      = 0;

	// Run statistics for the closing summary.
	int mismatches      = 0;
	int requests_sent   = 0;
	int results_checked = 0;
	int dropped_inserts = 0;
	int absent_hits     = 0;
	int times_full      = 0;

	// The random mix leans towards inserts while the list is growing and
	// towards deletes while it is shrinking, so that it sweeps between empty
	// and full many times over.
	bit growing = 1'b1;

	// Applies one request to our copy of the list and returns the result item
	// that the block must give for it.
	function automatic list_result_t apply_request(input logic [2:0] f,
			input logic [7:0] p, input logic [31:0] v);
		list_result_t res;
		logic [2:0]   op;
		int           i;
		res.read_value = '0;
		res.status     = ST_DONE;
		op = f;
		// An insert at position zero behaves exactly as an insert at the head.
		if (op == FUNC_INS_POS && p == 8'd0) begin
			op = FUNC_INS_HEAD;
		end
		case (op)
			FUNC_GET: begin
				if (p < list_len) begin
					res.read_value = list_store[p];
				end else begin
					res.read_value = PAD_WORD;
					res.status     = ST_ABSENT;
				end
			end
			FUNC_INS_HEAD: begin
				if (list_len >= LIST_CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					for (i = list_len; i > 0; i--) list_store[i] = list_store[i - 1];
					list_store[0] = v;
					list_len++;
				end
			end
			FUNC_APPEND: begin
				if (list_len >= LIST_CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					list_store[list_len] = v;
					list_len++;
				end
			end
			FUNC_INS_POS: begin
				if (p < list_len) begin
					if (list_len >= LIST_CAPACITY) begin
						res.status = ST_FULL;
					end else begin
						for (i = list_len; i > p; i--) list_store[i] = list_store[i - 1];
						list_store[p] = v;
						list_len++;
					end
				end else if (p + 1 > LIST_CAPACITY) begin
					// The padded list would not fit, so nothing is kept at all.
					res.status = ST_FULL;
				end else begin
					while (list_len < p) begin
						list_store[list_len] = PAD_WORD;
						list_len++;
					end
					list_store[list_len] = v;
					list_len++;
				end
			end
			FUNC_DELETE: begin
				if (p < list_len) begin
					for (i = p; i + 1 < list_len; i++) list_store[i] = list_store[i + 1];
					list_len--;
				end else begin
					res.status = ST_ABSENT;
				end
			end
			default: begin
			end
		endcase
		res.count_after = list_len[6:0];
		if (res.status == ST_FULL) dropped_inserts++;
		if (res.status == ST_ABSENT) absent_hits++;
		if (res.status == ST_DONE && list_len == LIST_CAPACITY &&
				(op == FUNC_INS_HEAD || op == FUNC_APPEND || op == FUNC_INS_POS)) begin
			times_full++;
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH at result %0d, %s: got %h, expected %h",
			results_checked, what, got, want);
		mismatches++;
	endtask

	task automatic add_row(input logic [2:0] op, input logic [7:0] pos,
			input logic [31:0] val, input logic typed, input logic [31:0] rd,
			input ple_status_e_t st, input logic [6:0] cnt);
		directed_row_t row;
		row.op               = op;
		row.pos              = pos;
		row.val              = val;
		row.typed            = typed;
		row.want.read_value  = rd;
		row.want.status      = st;
		row.want.count_after = cnt;
		directed_rows.push_back(row);
	endtask

	// Offers one item, possibly after a random gap, and books the expected
	// result at the edge where the block accepts it. The list model is only
	// advanced on acceptance, so the next pick always sees the true length.
	task automatic send_request(input logic [2:0] f, input logic [7:0] p,
			input logic [31:0] v, input logic typed, input list_result_t typed_res);
		list_result_t model_res;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		func       <= f;
		position   <= p;
		item_value <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		model_res = apply_request(f, p, v);
		awaited_results.push_back(typed ? typed_res : model_res);
		requests_sent++;
	endtask

	// Random request with the position mostly near the live length of the
	// list, where shifting and padding actually happen.
	task automatic pick_request(output logic [2:0] f, output logic [7:0] p,
			output logic [31:0] v);
		int k;
		int r;
		if (list_len >= LIST_CAPACITY && $urandom_range(0, 5) == 0) begin
			growing = 1'b0;
		end else if (list_len == 0 && $urandom_range(0, 2) == 0) begin
			growing = 1'b1;
		end
		k = $urandom_range(0, 99);
		r = $urandom_range(0, 99);
		p = 8'($urandom_range(0, 255));
		if (k < 3) begin
			f = 3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
		end else if (k < 23) begin
			f = FUNC_GET;
			if (r < 80) p = 8'($urandom_range(0, list_len));
		end else if (k < (growing ? 80 : 40)) begin
			case ($urandom_range(0, 2))
				0: f = FUNC_INS_HEAD;
				1: f = FUNC_APPEND;
				default: f = FUNC_INS_POS;
			endcase
			if (r < 75) begin
				p = 8'($urandom_range(0, list_len));
			end else if (r < 95) begin
				// Just past the end, so that the insert pads with -1 values.
				p = (list_len + $urandom_range(1, 6) > 255) ? 8'd255
					: 8'(list_len + $urandom_range(1, 6));
			end
		end else begin
			f = FUNC_DELETE;
			if (list_len > 0 && r < 85) p = 8'($urandom_range(0, list_len - 1));
		end
		v = $urandom();
		if ($urandom_range(0, 4) == 0) begin
			case ($urandom_range(0, 3))
				0: v = VAL_MAX;
				1: v = VAL_MIN;
				2: v = PAD_WORD;
				default: v = '0;
			endcase
		end
	endtask

	// The sender stops offering and waits until every booked result is in.
	task automatic wait_all_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited_results.size() != 0) @(posedge clk);
	endtask

	// Receiver side: checks each accepted result item against the oldest
	// expectation, then decides whether to stall on the next cycle. Values
	// are sampled as they stood before this edge.
	always @(posedge clk) begin : result_check
		list_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_results.size() == 0) begin
				report_mismatch("result with no request pending", read_value, '0);
			end else begin
				want = awaited_results.pop_front();
				if (read_value !== want.read_value) begin
					report_mismatch("read_value", read_value, want.read_value);
				end
				if (status !== want.status) begin
					report_mismatch("status", {30'd0, status}, {30'd0, want.status});
				end
				if (count_after !== want.count_after) begin
					report_mismatch("count_after", {25'd0, count_after},
						{25'd0, want.count_after});
				end
			end
			results_checked++;
		end
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Main sequence: reset, directed table, then five phases of random items
	// with different pacing on each side.
	initial begin : main_sequence
		logic [2:0]  f;
		logic [7:0]  p;
		logic [31:0] v;
		int          phase;
		int          n;
		directed_row_t row;

		// Directed table. Rows with a typed expectation are those whose answer
		// is plain from the list length alone; the rest rely on the model.
		add_row(FUNC_GET,       8'd0,   32'd0,         1'b1, PAD_WORD, ST_ABSENT, 7'd0);
		add_row(FUNC_DELETE,    8'd0,   32'd0,         1'b1, 32'd0,    ST_ABSENT, 7'd0);
		add_row(FUNC_APPEND,    8'd0,   VAL_MAX,       1'b1, 32'd0,    ST_DONE,   7'd1);
		add_row(FUNC_INS_HEAD,  8'd0,   VAL_MIN,       1'b1, 32'd0,    ST_DONE,   7'd2);
		add_row(FUNC_GET,       8'd0,   32'd0,         1'b0, 32'd0,    ST_DONE,   7'd0);
		add_row(FUNC_GET,       8'd1,   32'd0,         1'b0, 32'd0,    ST_DONE,   7'd0);
		// Insert at position zero must act as an insert at the head.
		add_row(FUNC_INS_POS,   8'd0,   32'd0,         1'b0, 32'd0,    ST_DONE,   7'd0);
		// Insert two places past the end: two -1 pads, then the value.
		add_row(FUNC_INS_POS,   8'd5,   32'hA5A5_A5A5, 1'b0, 32'd0,    ST_DONE,   7'd0);
		add_row(FUNC_GET,       8'd4,   32'd0,         1'b0, 32'd0,    ST_DONE,   7'd0);
		add_row(FUNC_GET,       8'd255, 32'd0,         1'b1, PAD_WORD, ST_ABSENT, 7'd6);
		add_row(FUNC_INS_POS,   8'd255, VAL_MAX,       1'b1, 32'd0,    ST_FULL,   7'd6);
		add_row(FUNC_INS_POS,   8'd64,  VAL_MIN,       1'b1, 32'd0,    ST_FULL,   7'd6);
		add_row(FUNC_DELETE,    8'd255, 32'd0,         1'b1, 32'd0,    ST_ABSENT, 7'd6);
		add_row(FUNC_DELETE,    8'd1,   32'd0,         1'b0, 32'd0,    ST_DONE,   7'd0);
		add_row(FUNC_SPARE_LO,  8'd0,   PAD_WORD,      1'b1, 32'd0,    ST_DONE,   7'd5);
		add_row(FUNC_SPARE_MID, 8'd255, VAL_MAX,       1'b1, 32'd0,    ST_DONE,   7'd5);
		add_row(FUNC_SPARE_HI,  8'd2,   VAL_MIN,       1'b1, 32'd0,    ST_DONE,   7'd5);
		// Pad right up to the last slot, which fills the list.
		add_row(FUNC_INS_POS,   8'd63,  32'h5A5A_5A5A, 1'b0, 32'd0,    ST_DONE,   7'd0);
		add_row(FUNC_APPEND,    8'd0,   32'd1,         1'b1, 32'd0,    ST_FULL,   7'd64);
		add_row(FUNC_INS_HEAD,  8'd0,   32'd2,         1'b1, 32'd0,    ST_FULL,   7'd64);
		add_row(FUNC_INS_POS,   8'd10,  32'd3,         1'b1, 32'd0,    ST_FULL,   7'd64);
		add_row(FUNC_GET,       8'd63,  32'd0,         1'b0, 32'd0,    ST_DONE,   7'd0);
		add_row(FUNC_DELETE,    8'd0,   32'd0,         1'b0, 32'd0,    ST_DONE,   7'd0);
		add_row(FUNC_DELETE,    8'd62,  32'd0,         1'b0, 32'd0,    ST_DONE,   7'd0);
		// Insert exactly at the end, which needs no padding.
		add_row(FUNC_INS_POS,   8'd62,  32'hFFFF_FFFE, 1'b0, 32'd0,    ST_DONE,   7'd0);
		add_row(FUNC_GET,       8'd62,  32'd0,         1'b0, 32'd0,    ST_DONE,   7'd0);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			send_request(row.op, row.pos, row.val, row.typed, row.want);
		end
		wait_all_results();

		// Phases: no idling, sender idle 70 %, receiver stalling 70 %, both
		// at 26 %, and finally no idling with a long receiver hold-off at the
		// start so that the block backs up and refuses new items.
		for (phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
				3: begin send_idle_pct = 26; recv_stall_pct = 26; end
				default: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
					hold_req       = 1'b1;
				end
			endcase
			for (n = 0; n < PHASE_ITEMS; n++) begin
				pick_request(f, p, v);
				send_request(f, p, v, 1'b0, '0);
			end
			wait_all_results();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (awaited_results.size() != 0) begin
			report_mismatch("results never delivered", awaited_results.size(), '0);
		end

		$display("Run covered %0d requests and %0d checked results over five pacing phases.",
			requests_sent, results_checked);
		$display("Inserts dropped as full: %0d, absent positions: %0d, list filled %0d times.",
			dropped_inserts, absent_hits, times_full);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin : watchdog
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("Timeout with %0d results still awaited.", awaited_results.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule : positional_list_engine_test
